// File: rtl/pctdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Percent decoder package
// Shared types, constants and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
package pctdec_pkg;

   localparam logic [7:0] PCT_CHAR            = 8'h25;
   localparam int         QUEUE_DEPTH_DEFAULT = 4;
   localparam int         MAX_BYTES           = 3;

   // Up to three output bytes caused by one request, packed from slot 0.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [1:0]                last_idx;
      logic                      string_last;
   } bundle_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) ||
               (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end
      hex_val = v[3:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/pctdec_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Percent decoder front end
// Runs the escape state machine on each request and hands the resulting
// output bytes to the queue as one bundle.
// ----------------------------------------------------------------------------
module pctdec_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_byte,
   input  wire logic                         req_last,
   input  wire pctdec_pkg::queue_status_type q_status,
   output logic                              push,
   output pctdec_pkg::bundle_type            push_data
);
   import pctdec_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_PCT   = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic [1:0] count;
   logic       ordinary;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      phase_in          = PH_IDLE;
      held_in           = held_ff;
      count             = 2'd0;
      ordinary          = 1'b0;
      push_data.bytes   = '0;
      push_data.string_last = req_last;
      unique case (phase_ff)
         PH_PCT: begin
            if (is_hex(req_byte) && !req_last) begin
               held_in  = req_byte;
               phase_in = PH_DIGIT;
            end else begin
               push_data.bytes[0] = PCT_CHAR;
               count    = 2'd1;
               ordinary = 1'b1;
            end
         end
         PH_DIGIT: begin
            if (is_hex(req_byte)) begin
               push_data.bytes[0] = {hex_val(held_ff), hex_val(req_byte)};
               count = 2'd1;
            end else begin
               push_data.bytes[0] = PCT_CHAR;
               push_data.bytes[1] = held_ff;
               count    = 2'd2;
               ordinary = 1'b1;
            end
            held_in = 8'h00;
         end
         default: begin
            ordinary = 1'b1;
         end
      endcase
      // The current byte is ordinary input: it may open a new escape.
      if (ordinary) begin
         if (req_byte == PCT_CHAR && !req_last) begin
            phase_in = PH_PCT;
         end else begin
            push_data.bytes[count] = req_byte;
            count = count + 2'd1;
         end
      end
      push_data.last_idx = count - 2'd1;
      push = accept && (count != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   property p_push_needs_accept;
      @(posedge clock) disable iff (reset) push |-> (req_valid && !req_stall);
   endproperty
   a_push_needs_accept: assert property (p_push_needs_accept)
      else $error("bundle pushed without an accepted request");

endmodule
`default_nettype wire

// File: rtl/pctdec_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Percent decoder bundle queue
// Short flip-flop FIFO that decouples the front end from the output side.
// ----------------------------------------------------------------------------
module pctdec_queue #(
   parameter int DEPTH = pctdec_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire pctdec_pkg::bundle_type  push_data,
   input  wire logic                    pop,
   output pctdec_pkg::bundle_type       head,
   output pctdec_pkg::queue_status_type status
);
   import pctdec_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   bundle_type    mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, count_in;

   assign head         = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: rtl/pctdec_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Percent decoder back end
// Walks the head bundle one byte per cycle unless rsp_stall holds it, and
// presents each byte on the response channel.
// ----------------------------------------------------------------------------
module pctdec_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pctdec_pkg::bundle_type       head,
   input  wire pctdec_pkg::queue_status_type q_status,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [7:0]                        rsp_byte,
   output logic                              rsp_run_end,
   output logic                              rsp_string_end
);
   import pctdec_pkg::*;

   logic [1:0] idx_ff;
   logic       take;

   assign rsp_valid      = !q_status.empty;
   assign rsp_byte       = head.bytes[idx_ff];
   assign rsp_run_end    = (idx_ff == head.last_idx);
   assign rsp_string_end = rsp_run_end && head.string_last;
   assign take           = rsp_valid && !rsp_stall;
   assign pop            = take && rsp_run_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else if (take) begin
         idx_ff <= rsp_run_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff <= head.last_idx))
      else $error("byte index past the end of the bundle");
   a_string_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_end)
      else $error("string end without run end");

endmodule
`default_nettype wire

// File: rtl/url_percent_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// URL percent decoder core
// Decodes a percent-encoded byte stream; broken escapes pass as literals.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Payload
//   req_     in         req_valid/stall    req_byte, req_last
//   rsp_     out        rsp_valid/stall    rsp_byte, rsp_run_end, rsp_string_end
//
// The front end takes one request per cycle while the queue has room.
// The back end sends one byte per cycle unless rsp_stall is high; a request
// yields zero to three bytes, and its bundle is popped after its last byte.
// Each bundle is registered in the queue before its first byte goes out.
// Synchronous reset clears the escape state and empties the queue.
// A stalled response holds its byte; requests stall only when the queue fills.
// ----------------------------------------------------------------------------
module url_percent_decoder_core #(
   parameter int QUEUE_DEPTH = pctdec_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_byte,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_byte,
   output logic            rsp_run_end,
   output logic            rsp_string_end
);
   import pctdec_pkg::*;

   bundle_type       push_data, head;
   queue_status_type q_status;
   logic             push, pop;

   pctdec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   pctdec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   pctdec_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte       (rsp_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

endmodule
`default_nettype wire
